[hw/rtl/cbt_pkg.sv]
// Shared widths, constants and inter-stage structs of the CAN bit timing calculator.
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    localparam int MAX_PRESCALER = 32;

    // port field widths
    localparam int CLK_W   = 28;
    localparam int RATE_W  = 24;
    localparam int SEG1_W  = 8;
    localparam int SEG2_W  = 7;
    localparam int PCODE_W = 5;
    localparam int SJW_W   = 7;

    localparam logic [CLK_W-1:0] CLK_FREQ_RESET = 28'd48000000;

    // clocks-per-bit divider: numerator is clock + rate/2
    localparam int NUM_W      = CLK_W + 1;
    localparam int PB_W       = NUM_W;
    localparam int RDIV_STEPS = NUM_W;

    // widths that hold whenever the prescaler is in range
    localparam int PRE_W = $clog2(MAX_PRESCALER + 1);
    localparam int BEF_W = $clog2(256 * MAX_PRESCALER + 1);
    localparam int AFT_W = $clog2(128 * MAX_PRESCALER + 1);

    // segment dividers
    localparam int SN_W       = BEF_W + 1;
    localparam int SD_W       = PRE_W + 2;
    localparam int SDIV_STEPS = SN_W;

    // input register + rate divider + two split stages + segment divider + output register
    localparam int LATENCY = 1 + RDIV_STEPS + 2 + SDIV_STEPS + 1;

    typedef struct packed {
        logic            vld;
        logic            bad;
        logic [PB_W-1:0] per_bit;
    } t_rate_res;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [BEF_W-1:0] bef;
        logic [AFT_W-1:0] after;
        logic [PRE_W-1:0] pre;
    } t_split_res;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [PRE_W-1:0] pre;
        logic [SN_W-1:0]  q1;
        logic [SN_W-1:0]  q2;
        logic [SN_W-1:0]  sjw;
    } t_seg_res;

endpackage

`default_nettype wire

[hw/rtl/cbt_rate_div.sv]
// Input register and pipelined restoring divider for rounded clocks per bit.
`timescale 1ns / 1ps
`default_nettype none

module cbt_rate_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [cbt_pkg::RATE_W-1:0]   i_rate,
    input  logic [cbt_pkg::CLK_W-1:0]    i_clk_freq,
    output cbt_pkg::t_rate_res           o_res
);

    typedef struct packed {
        logic                        bad;
        logic [cbt_pkg::NUM_W-1:0]   num;
        logic [cbt_pkg::RATE_W-1:0]  den;
        logic [cbt_pkg::RATE_W-1:0]  rem;
        logic [cbt_pkg::NUM_W-1:0]   quo;
    } t_rdiv_stage;

    t_rdiv_stage                   r_stg [0:cbt_pkg::RDIV_STEPS];
    t_rdiv_stage                   n_stg [0:cbt_pkg::RDIV_STEPS];
    logic [cbt_pkg::RDIV_STEPS:0]  r_vld;

    always_comb begin
        logic [cbt_pkg::RATE_W:0] sh;
        logic [cbt_pkg::RATE_W:0] diff;
        sh   = '0;
        diff = '0;
        // entry: numerator with half the divisor added for rounding
        n_stg[0].bad = (i_rate == '0);
        n_stg[0].num = (cbt_pkg::NUM_W)'(i_clk_freq) + (cbt_pkg::NUM_W)'(i_rate >> 1);
        n_stg[0].den = (i_rate == '0) ? (cbt_pkg::RATE_W)'(1) : i_rate;
        n_stg[0].rem = '0;
        n_stg[0].quo = '0;
        // one quotient bit per stage, MSB first
        for (int k = 1; k <= cbt_pkg::RDIV_STEPS; k++) begin
            sh   = {r_stg[k-1].rem, r_stg[k-1].num[cbt_pkg::NUM_W-1]};
            diff = sh - {1'b0, r_stg[k-1].den};
            n_stg[k].bad = r_stg[k-1].bad;
            n_stg[k].den = r_stg[k-1].den;
            n_stg[k].num = r_stg[k-1].num << 1;
            n_stg[k].rem = diff[cbt_pkg::RATE_W] ? sh[cbt_pkg::RATE_W-1:0]
                                                 : diff[cbt_pkg::RATE_W-1:0];
            n_stg[k].quo = {r_stg[k-1].quo[cbt_pkg::NUM_W-2:0], ~diff[cbt_pkg::RATE_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[cbt_pkg::RDIV_STEPS-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= cbt_pkg::RDIV_STEPS; k++) begin
            r_stg[k] <= n_stg[k];
        end
    end

    assign o_res.vld     = r_vld[cbt_pkg::RDIV_STEPS];
    assign o_res.bad     = r_stg[cbt_pkg::RDIV_STEPS].bad;
    assign o_res.per_bit = r_stg[cbt_pkg::RDIV_STEPS].quo;

endmodule

`default_nettype wire

[hw/rtl/cbt_split.sv]
// Two stages: split clocks per bit around the sample point, then pick and check the prescaler.
`timescale 1ns / 1ps
`default_nettype none

module cbt_split (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbt_pkg::t_rate_res   i_res,
    output cbt_pkg::t_split_res  o_res
);

    logic                      r_a_vld;
    logic                      r_a_bad;
    logic [cbt_pkg::PB_W-1:0]  r_a_bef;
    logic [cbt_pkg::PB_W-1:0]  r_a_aft;

    logic [cbt_pkg::PB_W+2:0]  w_prod7;
    logic [cbt_pkg::PB_W+2:0]  w_sum7;
    logic [cbt_pkg::PB_W-1:0]  n_a_bef;

    logic [cbt_pkg::PB_W:0]    w_sum_a;
    logic [cbt_pkg::PB_W:0]    w_sum_b;
    logic [cbt_pkg::PB_W:0]    w_pa;
    logic [cbt_pkg::PB_W:0]    w_pb;
    logic [cbt_pkg::PB_W:0]    w_pre;
    logic                      n_ok;

    cbt_pkg::t_split_res       r_res;

    // before = round(per_bit * 7 / 8)
    assign w_prod7 = ({3'b000, i_res.per_bit} << 3) - {3'b000, i_res.per_bit};
    assign w_sum7  = w_prod7 + (cbt_pkg::PB_W + 3)'(4);
    assign n_a_bef = w_sum7[cbt_pkg::PB_W+2:3];

    // prescaler = max(ceil(before/256), ceil(after/128))
    assign w_sum_a = {1'b0, r_a_bef} + (cbt_pkg::PB_W + 1)'(255);
    assign w_sum_b = {1'b0, r_a_aft} + (cbt_pkg::PB_W + 1)'(127);
    assign w_pa    = w_sum_a >> 8;
    assign w_pb    = w_sum_b >> 7;
    assign w_pre   = (w_pa > w_pb) ? w_pa : w_pb;
    assign n_ok    = !r_a_bad && (w_pre != '0)
                     && (w_pre <= (cbt_pkg::PB_W + 1)'(cbt_pkg::MAX_PRESCALER));

    // values are narrowed here: they only matter when the prescaler is in range
    always_ff @(posedge i_clk) begin
        r_a_bad      <= i_res.bad;
        r_a_bef      <= n_a_bef;
        r_a_aft      <= i_res.per_bit - n_a_bef;
        r_res.ok     <= n_ok;
        r_res.bef    <= r_a_bef[cbt_pkg::BEF_W-1:0];
        r_res.after  <= r_a_aft[cbt_pkg::AFT_W-1:0];
        r_res.pre    <= w_pre[cbt_pkg::PRE_W-1:0];
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_res.vld <= 1'b0;
        end else begin
            r_a_vld   <= i_res.vld;
            r_res.vld <= r_a_vld;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[hw/rtl/cbt_seg_div.sv]
// Pipelined restoring dividers: both segments by prescaler, jump width by 4 * prescaler.
`timescale 1ns / 1ps
`default_nettype none

module cbt_seg_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbt_pkg::t_split_res  i_res,
    output cbt_pkg::t_seg_res    o_res
);

    localparam int LANES = 3;

    typedef struct packed {
        logic [cbt_pkg::SN_W-1:0]  num;
        logic [cbt_pkg::SD_W-1:0]  den;
        logic [cbt_pkg::SD_W-1:0]  rem;
        logic [cbt_pkg::SN_W-1:0]  quo;
    } t_sdiv_lane;

    typedef struct packed {
        logic                       ok;
        logic [cbt_pkg::PRE_W-1:0]  pre;
        t_sdiv_lane [LANES-1:0]     lane;
    } t_sdiv_stage;

    t_sdiv_stage                       w_s0;
    t_sdiv_stage                       r_stg [0:cbt_pkg::SDIV_STEPS-1];
    t_sdiv_stage                       n_stg [0:cbt_pkg::SDIV_STEPS-1];
    logic [cbt_pkg::SDIV_STEPS-1:0]    r_vld;

    logic [cbt_pkg::SD_W-1:0]          w_pre_d;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [cbt_pkg::SD_W:0] sdiv_step(
        input t_sdiv_lane l
    );
        logic [cbt_pkg::SD_W:0] sh;
        logic [cbt_pkg::SD_W:0] diff;
        sh   = {l.rem, l.num[cbt_pkg::SN_W-1]};
        diff = sh - {1'b0, l.den};
        if (diff[cbt_pkg::SD_W]) begin
            sdiv_step = {1'b0, sh[cbt_pkg::SD_W-1:0]};
        end else begin
            sdiv_step = {1'b1, diff[cbt_pkg::SD_W-1:0]};
        end
    endfunction

    assign w_pre_d = (cbt_pkg::SD_W)'(i_res.pre);

    always_comb begin
        w_s0.ok  = i_res.ok;
        w_s0.pre = i_res.pre;
        // lane 0: round(before / pre)
        w_s0.lane[0].num = (cbt_pkg::SN_W)'(i_res.bef) + (cbt_pkg::SN_W)'(i_res.pre >> 1);
        w_s0.lane[0].den = w_pre_d;
        // lane 1: round(after / pre)
        w_s0.lane[1].num = (cbt_pkg::SN_W)'(i_res.after) + (cbt_pkg::SN_W)'(i_res.pre >> 1);
        w_s0.lane[1].den = w_pre_d;
        // lane 2: round(after / (4 * pre))
        w_s0.lane[2].num = (cbt_pkg::SN_W)'(i_res.after)
                           + ((cbt_pkg::SN_W)'(i_res.pre) << 1);
        w_s0.lane[2].den = w_pre_d << 2;
        for (int j = 0; j < LANES; j++) begin
            w_s0.lane[j].rem = '0;
            w_s0.lane[j].quo = '0;
        end
    end

    always_comb begin
        t_sdiv_stage            prev;
        logic [cbt_pkg::SD_W:0] st;
        prev = w_s0;
        st   = '0;
        for (int k = 0; k < cbt_pkg::SDIV_STEPS; k++) begin
            prev = (k == 0) ? w_s0 : r_stg[(k == 0) ? 0 : k - 1];
            n_stg[k].ok  = prev.ok;
            n_stg[k].pre = prev.pre;
            for (int j = 0; j < LANES; j++) begin
                st = sdiv_step(prev.lane[j]);
                n_stg[k].lane[j].num = prev.lane[j].num << 1;
                n_stg[k].lane[j].den = prev.lane[j].den;
                n_stg[k].lane[j].rem = st[cbt_pkg::SD_W-1:0];
                n_stg[k].lane[j].quo = {prev.lane[j].quo[cbt_pkg::SN_W-2:0], st[cbt_pkg::SD_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[cbt_pkg::SDIV_STEPS-2:0], i_res.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cbt_pkg::SDIV_STEPS; k++) begin
            r_stg[k] <= n_stg[k];
        end
    end

    assign o_res.vld = r_vld[cbt_pkg::SDIV_STEPS-1];
    assign o_res.ok  = r_stg[cbt_pkg::SDIV_STEPS-1].ok;
    assign o_res.pre = r_stg[cbt_pkg::SDIV_STEPS-1].pre;
    assign o_res.q1  = r_stg[cbt_pkg::SDIV_STEPS-1].lane[0].quo;
    assign o_res.q2  = r_stg[cbt_pkg::SDIV_STEPS-1].lane[1].quo;
    assign o_res.sjw = r_stg[cbt_pkg::SDIV_STEPS-1].lane[2].quo;

endmodule

`default_nettype wire

[hw/rtl/can_bit_timing_calc.sv]
// Top level of the CAN nominal bit timing calculator: config register, pipeline, result register.
//
//  channel   direction  handshake                       payload
//  -------   ---------  ------------------------------  ---------------------------------------
//  request   in         start && !busy                  i_bit_rate[23:0]
//  result    out        o_done, one cycle, no backpress  o_valid_res, o_segment_one[7:0],
//                                                       o_segment_two[6:0], o_prescaler_code[4:0],
//                                                       o_jump_width[6:0]
//  config    in         i_cfg_we                        i_cfg_wdata[27:0] (clock frequency, Hz)
//
// A request can enter every cycle; busy is always low. Each result strobes o_done once its
// request has passed the pipeline (1 input register, 29 rate divider stages, 2 split
// stages, 15 segment divider stages, 1 output register); the 29-stage clocks-per-bit divider
// is the largest part of it. Synchronous active-low reset empties the pipeline and loads the
// clock frequency register with 48 MHz. Results cannot be held off, so nothing stalls.
`timescale 1ns / 1ps
`default_nettype none

module can_bit_timing_calc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cbt_pkg::RATE_W-1:0]    i_bit_rate,
    input  logic                          i_cfg_we,
    input  logic [cbt_pkg::CLK_W-1:0]     i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_valid_res,
    output logic [cbt_pkg::SEG1_W-1:0]    o_segment_one,
    output logic [cbt_pkg::SEG2_W-1:0]    o_segment_two,
    output logic [cbt_pkg::PCODE_W-1:0]   o_prescaler_code,
    output logic [cbt_pkg::SJW_W-1:0]     o_jump_width
);

    logic [cbt_pkg::CLK_W-1:0]    r_clk_freq;
    cbt_pkg::t_rate_res           w_rate_res;
    cbt_pkg::t_split_res          w_split_res;
    cbt_pkg::t_seg_res            w_seg_res;

    logic                         w_accept;
    logic                         n_valid;

    logic                         r_done;
    logic                         r_valid_res;
    logic [cbt_pkg::SEG1_W-1:0]   r_segment_one;
    logic [cbt_pkg::SEG2_W-1:0]   r_segment_two;
    logic [cbt_pkg::PCODE_W-1:0]  r_prescaler_code;
    logic [cbt_pkg::SJW_W-1:0]    r_jump_width;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_freq <= cbt_pkg::CLK_FREQ_RESET;
        end else if (i_cfg_we) begin
            r_clk_freq <= i_cfg_wdata;
        end
    end

    cbt_rate_div u_rate_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_accept),
        .i_rate     (i_bit_rate),
        .i_clk_freq (r_clk_freq),
        .o_res      (w_rate_res)
    );

    cbt_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_rate_res),
        .o_res   (w_split_res)
    );

    cbt_seg_div u_seg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_split_res),
        .o_res   (w_seg_res)
    );

    // reject a segment that would go negative
    assign n_valid = w_seg_res.ok
                     && (w_seg_res.q1 >= (cbt_pkg::SN_W)'(2))
                     && (w_seg_res.q2 >= (cbt_pkg::SN_W)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_valid_res <= 1'b0;
        end else begin
            r_done      <= w_seg_res.vld;
            r_valid_res <= w_seg_res.vld && n_valid;
        end
    end

    // zero the fields of a rejected transaction
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_segment_one    <= (cbt_pkg::SEG1_W)'(w_seg_res.q1 - (cbt_pkg::SN_W)'(2));
            r_segment_two    <= (cbt_pkg::SEG2_W)'(w_seg_res.q2 - (cbt_pkg::SN_W)'(1));
            r_prescaler_code <= (cbt_pkg::PCODE_W)'(w_seg_res.pre - (cbt_pkg::PRE_W)'(1));
            r_jump_width     <= (cbt_pkg::SJW_W)'(w_seg_res.sjw);
        end else begin
            r_segment_one    <= '0;
            r_segment_two    <= '0;
            r_prescaler_code <= '0;
            r_jump_width     <= '0;
        end
    end

    assign o_done           = r_done;
    assign o_valid_res      = r_valid_res;
    assign o_segment_one    = r_segment_one;
    assign o_segment_two    = r_segment_two;
    assign o_prescaler_code = r_prescaler_code;
    assign o_jump_width     = r_jump_width;

    // every result strobe traces back to an accepted request through the whole pipeline
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept, cbt_pkg::LATENCY))
        else $error("result strobe without a matching request");

    // a zero bit rate must come out rejected
    a_zero_rate_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(w_accept && (i_bit_rate == '0), cbt_pkg::LATENCY)) |-> !o_valid_res)
        else $error("zero bit rate accepted as valid timing");

    a_valid_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid_res |-> o_done)
        else $error("valid flag outside a result strobe");

    a_reject_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_valid_res) |-> ((o_segment_one == '0) && (o_segment_two == '0)
            && (o_prescaler_code == '0) && (o_jump_width == '0)))
        else $error("rejected result carries nonzero fields");

endmodule

`default_nettype wire

[bench/can_bit_timing_calc_tb.sv]
// Self-checking bench for the CAN bit timing calculator: directed and random bit rates.
`timescale 1ns / 1ps

module can_bit_timing_calc_tb;
    import cbt_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 180;
    localparam int CALM_ITEMS  = 150;

    typedef struct packed {
        logic               valid;
        logic [SEG1_W-1:0]  seg1;
        logic [SEG2_W-1:0]  seg2;
        logic [PCODE_W-1:0] pcode;
        logic [SJW_W-1:0]   sjw;
    } timing_t;

    typedef enum logic [1:0] {
        REQ_RATE,
        REQ_CLOCK,
        REQ_DRAIN
    } req_kind_e;

    typedef struct {
        req_kind_e        kind;
        logic [CLK_W-1:0] value;
        bit               calm;
    } request_t;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [RATE_W-1:0]   i_bit_rate = '0;
    logic                i_cfg_we = 1'b0;
    logic [CLK_W-1:0]    i_cfg_wdata = '0;
    logic                o_done;
    logic                o_valid_res;
    logic [SEG1_W-1:0]   o_segment_one;
    logic [SEG2_W-1:0]   o_segment_two;
    logic [PCODE_W-1:0]  o_prescaler_code;
    logic [SJW_W-1:0]    o_jump_width;

    request_t         request_q[$];
    timing_t          timing_q[$];
    logic [CLK_W-1:0] clk_hz_cur = CLK_FREQ_RESET;
    int               idle_left = 0;
    int               fail_cnt = 0;

    can_bit_timing_calc uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_bit_rate       (i_bit_rate),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_valid_res      (o_valid_res),
        .o_segment_one    (o_segment_one),
        .o_segment_two    (o_segment_two),
        .o_prescaler_code (o_prescaler_code),
        .o_jump_width     (o_jump_width)
    );

    // Nominal timing for one bit rate at the given controller clock.
    function automatic timing_t calc_timing(input logic [CLK_W-1:0] clk_hz,
                                            input logic [RATE_W-1:0] rate);
        longint unsigned clk_l, rate_l, per_bit, pre_sp, post_sp, pre, pre_b, q1, q2, sjw;
        timing_t res;
        res = '0;
        clk_l = clk_hz;
        rate_l = rate;
        if (rate_l == 0) return res;
        per_bit = (clk_l + rate_l / 2) / rate_l;
        pre_sp  = (per_bit * 7 + 4) / 8;
        post_sp = per_bit - pre_sp;
        pre     = (pre_sp + 255) / 256;
        pre_b   = (post_sp + 127) / 128;
        if (pre_b > pre) pre = pre_b;
        if (pre == 0 || pre > MAX_PRESCALER) return res;
        q1 = (pre_sp + pre / 2) / pre;
        q2 = (post_sp + pre / 2) / pre;
        if (q1 < 2 || q2 < 1) return res;
        sjw = (post_sp + pre * 2) / (pre * 4);
        res.valid = 1'b1;
        res.seg1  = SEG1_W'(q1 - 2);
        res.seg2  = SEG2_W'(q2 - 1);
        res.pcode = PCODE_W'(pre - 1);
        res.sjw   = SJW_W'(sjw);
        return res;
    endfunction

    function automatic void push_rate(input logic [RATE_W-1:0] rate, input bit calm);
        request_t req;
        req.kind  = REQ_RATE;
        req.value = CLK_W'(rate);
        req.calm  = calm;
        request_q.push_back(req);
    endfunction

    function automatic void push_marker(input req_kind_e kind, input logic [CLK_W-1:0] value);
        request_t req;
        req.kind  = kind;
        req.value = value;
        req.calm  = 1'b0;
        request_q.push_back(req);
    endfunction

    // One clock setting: write it, then rates, most near an integer fraction of that clock.
    task automatic run_phase(input logic [CLK_W-1:0] clk_hz, input int n, input int calm_from);
        longint r;
        int unsigned ticks;
        int sel;
        push_marker(REQ_CLOCK, clk_hz);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) push_marker(REQ_DRAIN, '0);
            sel = $urandom_range(99);
            if (sel < 70) begin
                ticks = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 10000);
                r = longint'(clk_hz) / ticks + longint'($urandom_range(4)) - 2;
                if (r < 0) r = 0;
                if (r > 64'hFFFFFF) r = $urandom_range(24'hFFFFFF);
            end else if (sel < 85) begin
                r = $urandom_range(24'hFFFFFF);
            end else if (sel < 93) begin
                r = $urandom_range(255);
            end else begin
                case ($urandom_range(3))
                    0: r = 0;
                    1: r = 1;
                    2: r = 64'hFFFFFF;
                    default: r = longint'(clk_hz) / 5;
                endcase
                if (r > 64'hFFFFFF) r = 64'hFFFFFF;
            end
            push_rate(RATE_W'(r), i >= calm_from);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // Driver: one transaction per cycle at most, hold clock writes until the pipe is empty.
    always @(posedge i_clk) begin : drive
        request_t          req;
        logic              nxt_start;
        logic              nxt_we;
        logic [RATE_W-1:0] nxt_rate;
        logic [CLK_W-1:0]  nxt_wdata;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            if (start && !busy) timing_q.push_back(calc_timing(clk_hz_cur, i_bit_rate));
            if (i_cfg_we) clk_hz_cur = i_cfg_wdata;
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            nxt_rate  = RATE_W'($urandom);
            nxt_wdata = i_cfg_wdata;
            if (idle_left > 0) begin
                idle_left--;
            end else if (request_q.size() != 0) begin
                req = request_q[0];
                case (req.kind)
                    REQ_RATE: begin
                        nxt_start = 1'b1;
                        nxt_rate  = req.value[RATE_W-1:0];
                        void'(request_q.pop_front());
                        if (!req.calm && $urandom_range(3) == 0) idle_left = $urandom_range(1, 8);
                    end
                    REQ_CLOCK: begin
                        if (timing_q.size() == 0 && !i_cfg_we) begin
                            nxt_we    = 1'b1;
                            nxt_wdata = req.value;
                            void'(request_q.pop_front());
                        end
                    end
                    default: begin
                        if (timing_q.size() == 0) void'(request_q.pop_front());
                    end
                endcase
            end
            start       <= nxt_start;
            i_bit_rate  <= nxt_rate;
            i_cfg_we    <= nxt_we;
            i_cfg_wdata <= nxt_wdata;
        end
    end

    always @(posedge i_clk) begin : monitor
        timing_t want;
        if (i_rst_n && o_done) begin
            if (timing_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_cnt++;
            end else begin
                want = timing_q.pop_front();
                if (o_valid_res !== want.valid) begin
                    $error("valid_res: expected %0d, got %0d", want.valid, o_valid_res);
                    fail_cnt++;
                end
                if (o_segment_one !== want.seg1) begin
                    $error("segment_one: expected %0d, got %0d", want.seg1, o_segment_one);
                    fail_cnt++;
                end
                if (o_segment_two !== want.seg2) begin
                    $error("segment_two: expected %0d, got %0d", want.seg2, o_segment_two);
                    fail_cnt++;
                end
                if (o_prescaler_code !== want.pcode) begin
                    $error("prescaler_code: expected %0d, got %0d", want.pcode,
                           o_prescaler_code);
                    fail_cnt++;
                end
                if (o_jump_width !== want.sjw) begin
                    $error("jump_width: expected %0d, got %0d", want.sjw, o_jump_width);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        // directed rates at the reset clock of 48 MHz
        push_rate(24'd0, 1'b0);          // zero rate
        push_rate(24'd1, 1'b0);
        push_rate(24'hFFFFFF, 1'b0);
        push_rate(24'h800000, 1'b0);
        push_rate(24'h7FFFFF, 1'b0);
        push_rate(24'd16000000, 1'b0);   // nothing left after the sample point
        push_rate(24'd12000000, 1'b0);   // nothing left after the sample point
        push_rate(24'd9600000, 1'b0);    // shortest valid bit
        push_rate(24'd1000000, 1'b0);
        push_rate(24'd500000, 1'b0);
        push_rate(24'd250000, 1'b0);
        push_rate(24'd125000, 1'b0);
        push_rate(24'd83333, 1'b0);
        push_rate(24'd20000, 1'b0);
        push_rate(24'd10000, 1'b0);
        push_rate(24'd5129, 1'b0);
        push_rate(24'd5128, 1'b0);       // prescaler at its limit
        push_rate(24'd5127, 1'b0);
        push_rate(24'd5000, 1'b0);       // prescaler too large
        push_rate(24'd1200, 1'b0);
        push_marker(REQ_DRAIN, '0);

        run_phase(28'd48000000, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd1000000, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd200000000, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd0, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'hFFFFFFF, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd80000000, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(CLK_W'($urandom_range(200000000, 1000000)), PHASE_ITEMS, PHASE_ITEMS);
        run_phase(CLK_W'($urandom_range(28'hFFFFFFF)), PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd16000000, PHASE_ITEMS, PHASE_ITEMS);
        run_phase(28'd48000000, PHASE_ITEMS, PHASE_ITEMS - CALM_ITEMS);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample at the falling edge so the driver's updates have settled
        while (request_q.size() != 0 || timing_q.size() != 0 || start) @(negedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (timing_q.size() != 0) begin
            $error("%0d results never arrived", timing_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
